>>> src/clock_face_pixel_generator_assert.svh
`ifndef CLOCK_FACE_PIXEL_GENERATOR_ASSERT_SVH
`define CLOCK_FACE_PIXEL_GENERATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CFPG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("clock face pixel generator assertion failed");

// next-cycle implication, disabled during reset
`define CFPG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("clock face pixel generator assertion failed");

`endif

>>> src/cfpg_pkg.sv
package cfpg_pkg;

	localparam int CELL_PIXELS = 6;
	localparam int COLUMNS     = 24;
	localparam int ROWS        = 28;

	// reciprocal divide by the cell size
	localparam int DIV_SHIFT = 16;
	localparam int DIV_RECIP = (1 << DIV_SHIFT) / CELL_PIXELS;
	localparam int PROD_W    = 8 + DIV_SHIFT;
	localparam int BACK_W    = 13;

	localparam int QW = $clog2(255 / CELL_PIXELS + 1);
	localparam int RW = $clog2(CELL_PIXELS);

	typedef logic [QW-1:0] cell_idx_t;
	typedef logic [RW-1:0] cell_off_t;

	typedef enum logic [1:0] {
		COLOR_BLACK = 2'd0,
		COLOR_GRAY  = 2'd1,
		COLOR_WHITE = 2'd2
	} color_t;

	typedef enum logic [0:0] {
		REG_HOUR_FORMAT_24 = 1'b0,
		REG_COLOR_DISPLAY  = 1'b1
	} cfg_reg_t;

	localparam logic [3:0] BLANK_DIGIT = 4'd10;

endpackage

>>> src/clock_face_pixel_generator.sv
// clock face pixel generator, four register stages
// a pixel accepted at a clock edge shows its color on pixel_color,
//   marked by done, once it has passed all four register stages
// throughput: one pixel every cycle, busy is always low, done is never held off
// reset: arst_n low clears the stage valid bits and sets both mode registers to 1
`include "clock_face_pixel_generator_assert.svh"

module clock_face_pixel_generator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] pixel_x,
	input  logic [7:0] pixel_y,
	input  logic [4:0] hour,
	input  logic [5:0] minute,
	output logic       done,
	output logic [1:0] pixel_color,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic       cfg_data
);

	localparam logic [3:0] DIGIT_ROWS [10][9] = '{
		'{4'hF, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'hF},
		'{4'h2, 4'h2, 4'hE, 4'h2, 4'h2, 4'h2, 4'h2, 4'h2, 4'hF},
		'{4'hF, 4'h1, 4'h1, 4'h1, 4'hF, 4'h8, 4'h8, 4'h8, 4'hF},
		'{4'hF, 4'h1, 4'h1, 4'h1, 4'hF, 4'h1, 4'h1, 4'h1, 4'hF},
		'{4'h9, 4'h9, 4'h9, 4'h9, 4'hF, 4'h1, 4'h1, 4'h1, 4'h1},
		'{4'hF, 4'h8, 4'h8, 4'h8, 4'hF, 4'h1, 4'h1, 4'h1, 4'hF},
		'{4'hF, 4'h8, 4'h8, 4'h8, 4'hF, 4'h9, 4'h9, 4'h9, 4'hF},
		'{4'hF, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1},
		'{4'hF, 4'h9, 4'h9, 4'h9, 4'hF, 4'h9, 4'h9, 4'h9, 4'hF},
		'{4'hF, 4'h9, 4'h9, 4'h9, 4'hF, 4'h1, 4'h1, 4'h1, 4'hF}
	};
	// bit n is glyph row n
	localparam logic [8:0] COLON_ROWS = 9'b001101100;

	localparam logic [7:0] GLYPH_ROW0 = 8'd10;
	localparam logic [7:0] GLYPH_ROW_END = 8'd19;

	function automatic logic glyph_lit(input logic [7:0] col, input logic [7:0] row,
			input logic [3:0] d0, input logic [3:0] d1,
			input logic [3:0] d2, input logic [3:0] d3);
		logic [7:0] gr8;
		logic [3:0] gr;
		logic [3:0] d;
		logic [1:0] off;
		logic       hit;
		logic       lit;
		gr8 = row - GLYPH_ROW0;
		gr  = gr8[3:0];
		d   = '0;
		off = '0;
		hit = 1'b0;
		lit = 1'b0;
		if (row >= GLYPH_ROW0 && row < GLYPH_ROW_END) begin
			if (col >= 8'd11 && col <= 8'd12) begin
				lit = COLON_ROWS[gr];
			end else if (col >= 8'd1 && col <= 8'd4) begin
				d = d0; off = 2'(col - 8'd1); hit = 1'b1;
			end else if (col >= 8'd6 && col <= 8'd9) begin
				d = d1; off = 2'(col - 8'd6); hit = 1'b1;
			end else if (col >= 8'd14 && col <= 8'd17) begin
				d = d2; off = 2'(col - 8'd14); hit = 1'b1;
			end else if (col >= 8'd19 && col <= 8'd22) begin
				d = d3; off = 2'(col - 8'd19); hit = 1'b1;
			end
			if (hit && d < cfpg_pkg::BLANK_DIGIT) begin
				lit = DIGIT_ROWS[d][gr][2'd3 - off];
			end
		end
		return lit;
	endfunction

	logic hour_format_24_q;
	logic color_display_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4;

	logic [4:0] hour_s1;
	logic [5:0] minute_s1;
	logic       blank_s1;
	logic [3:0] d0_s2, d1_s2, d2_s2, d3_s2;
	logic       outside_s3, lit_s3, anti_s3, diag_s3;
	cfpg_pkg::color_t color_s4;

	logic [4:0] h_clamp;
	logic [4:0] h_fmt;
	logic [5:0] m_clamp;
	logic [3:0] h_tens, h_ones, m_tens, m_ones;
	logic [4:0] h_rem;
	logic [5:0] m_rem;

	cfpg_pkg::cell_idx_t col, row;
	cfpg_pkg::cell_off_t px, py;
	logic [cfpg_pkg::RW:0] off_sum;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_format_24_q <= 1'b1;
			color_display_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cfpg_pkg::REG_HOUR_FORMAT_24: hour_format_24_q <= cfg_data;
				cfpg_pkg::REG_COLOR_DISPLAY:  color_display_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	cfpg_div u_div_x (
		.clk  (clk),
		.din  (pixel_x),
		.quot (col),
		.rem  (px)
	);

	cfpg_div u_div_y (
		.clk  (clk),
		.din  (pixel_y),
		.quot (row),
		.rem  (py)
	);

	// stage 1: clamp and hour format
	always_comb begin
		h_clamp = (hour > 5'd23) ? 5'd23 : hour;
		m_clamp = (minute > 6'd59) ? 6'd59 : minute;
		h_fmt   = h_clamp;
		if (!hour_format_24_q) begin
			if (h_clamp >= 5'd12) begin
				h_fmt = h_clamp - 5'd12;
			end
			if (h_fmt == 5'd0) begin
				h_fmt = 5'd12;
			end
		end
	end

	always_ff @(posedge clk) begin
		hour_s1   <= h_fmt;
		minute_s1 <= m_clamp;
		blank_s1  <= !hour_format_24_q && (h_fmt < 5'd10);
	end

	// stage 2: split into digits
	always_comb begin
		if (hour_s1 >= 5'd20) begin
			h_tens = 4'd2; h_rem = hour_s1 - 5'd20;
		end else if (hour_s1 >= 5'd10) begin
			h_tens = 4'd1; h_rem = hour_s1 - 5'd10;
		end else begin
			h_tens = 4'd0; h_rem = hour_s1;
		end
		h_ones = h_rem[3:0];
		if (minute_s1 >= 6'd50) begin
			m_tens = 4'd5; m_rem = minute_s1 - 6'd50;
		end else if (minute_s1 >= 6'd40) begin
			m_tens = 4'd4; m_rem = minute_s1 - 6'd40;
		end else if (minute_s1 >= 6'd30) begin
			m_tens = 4'd3; m_rem = minute_s1 - 6'd30;
		end else if (minute_s1 >= 6'd20) begin
			m_tens = 4'd2; m_rem = minute_s1 - 6'd20;
		end else if (minute_s1 >= 6'd10) begin
			m_tens = 4'd1; m_rem = minute_s1 - 6'd10;
		end else begin
			m_tens = 4'd0; m_rem = minute_s1;
		end
		m_ones = m_rem[3:0];
	end

	always_ff @(posedge clk) begin
		d0_s2 <= blank_s1 ? cfpg_pkg::BLANK_DIGIT : h_tens;
		d1_s2 <= h_ones;
		d2_s2 <= m_tens;
		d3_s2 <= m_ones;
	end

	// stage 3: cell classification
	assign off_sum = {1'b0, px} + {1'b0, py};

	always_ff @(posedge clk) begin
		outside_s3 <= (32'(col) >= 32'(cfpg_pkg::COLUMNS)) ||
			(32'(row) >= 32'(cfpg_pkg::ROWS));
		lit_s3     <= glyph_lit(8'(col), 8'(row), d0_s2, d1_s2, d2_s2, d3_s2);
		anti_s3    <= off_sum == (cfpg_pkg::RW+1)'(cfpg_pkg::CELL_PIXELS - 1);
		diag_s3    <= px == py;
	end

	// stage 4: color
	always_ff @(posedge clk) begin
		if (outside_s3) begin
			color_s4 <= color_display_q ? cfpg_pkg::COLOR_BLACK : cfpg_pkg::COLOR_WHITE;
		end else if (lit_s3) begin
			color_s4 <= anti_s3 ? cfpg_pkg::COLOR_WHITE :
				(color_display_q ? cfpg_pkg::COLOR_GRAY : cfpg_pkg::COLOR_WHITE);
		end else begin
			color_s4 <= diag_s3 ? cfpg_pkg::COLOR_BLACK :
				(color_display_q ? cfpg_pkg::COLOR_GRAY : cfpg_pkg::COLOR_WHITE);
		end
	end

	assign done        = valid_s4;
	assign pixel_color = color_s4;

	`CFPG_ASSERT_IMP(a_latency, clk, arst_n, start && !busy, ##4 done)
	`CFPG_ASSERT_IMP(a_no_spurious, clk, arst_n, done, $past(start && !busy, 4))
	`CFPG_ASSERT_IMP(a_gray_color_only, clk, arst_n, done && (pixel_color == cfpg_pkg::COLOR_GRAY), $past(color_display_q))

endmodule

>>> src/cfpg_div.sv
module cfpg_div (
	input  logic                 clk,
	input  logic [7:0]           din,
	output cfpg_pkg::cell_idx_t  quot,
	output cfpg_pkg::cell_off_t  rem
);

	logic [cfpg_pkg::PROD_W-1:0] prod_s1;
	logic [7:0]                  din_s1;
	logic [7:0]                  q_est;
	logic [cfpg_pkg::BACK_W-1:0] back;
	logic [cfpg_pkg::BACK_W-1:0] diff;
	logic                        corr;
	cfpg_pkg::cell_idx_t         quot_s2;
	cfpg_pkg::cell_off_t         rem_s2;

	always_ff @(posedge clk) begin
		prod_s1 <= cfpg_pkg::PROD_W'(din) * cfpg_pkg::PROD_W'(cfpg_pkg::DIV_RECIP);
		din_s1  <= din;
	end

	// estimate is exact or one low
	always_comb begin
		q_est = prod_s1[cfpg_pkg::PROD_W-1:cfpg_pkg::DIV_SHIFT];
		back  = cfpg_pkg::BACK_W'(q_est) * cfpg_pkg::BACK_W'(cfpg_pkg::CELL_PIXELS);
		diff  = cfpg_pkg::BACK_W'(din_s1) - back;
		corr  = diff >= cfpg_pkg::BACK_W'(cfpg_pkg::CELL_PIXELS);
	end

	always_ff @(posedge clk) begin
		if (corr) begin
			quot_s2 <= cfpg_pkg::QW'(q_est + 8'd1);
			rem_s2  <= cfpg_pkg::RW'(diff - cfpg_pkg::BACK_W'(cfpg_pkg::CELL_PIXELS));
		end else begin
			quot_s2 <= cfpg_pkg::QW'(q_est);
			rem_s2  <= cfpg_pkg::RW'(diff);
		end
	end

	assign quot = quot_s2;
	assign rem  = rem_s2;

endmodule

>>> bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cfpg_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 12;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_PIXELS = 160;

	localparam int MAX_HOUR = 23;
	localparam int MAX_MINUTE = 59;
	localparam int GLYPH_ROW0 = 10;
	localparam int GLYPH_ROWS = 9;
	localparam int GLYPH_W = 4;
	localparam int COLON_W = 2;
	localparam int HOUR_TENS_COL = 1;
	localparam int HOUR_ONES_COL = 6;
	localparam int COLON_COL = 11;
	localparam int MIN_TENS_COL = 14;
	localparam int MIN_ONES_COL = 19;
	localparam logic [8:0] COLON_ROWS = 9'b001101100;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [7:0] pixel_x;
	logic [7:0] pixel_y;
	logic [4:0] hour;
	logic [5:0] minute;
	logic       done;
	logic [1:0] pixel_color;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [0:0] cfg_index;
	logic       cfg_data;

	logic   show_24h;
	logic   color_panel;
	logic   gaps_on;
	color_t expected_colors[$];
	color_t expected_head;
	int     fault_count;
	int     cycle_count;

	clock_face_pixel_generator i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.hour       (hour),
		.minute     (minute),
		.done       (done),
		.pixel_color(pixel_color),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// bitmap rows top to bottom, one nibble per row, msb is the leftmost cell
	function automatic logic [35:0] digit_font(input int d);
		case (d)
			0: return 36'hF9999999F;
			1: return 36'h22E22222F;
			2: return 36'hF111F888F;
			3: return 36'hF111F111F;
			4: return 36'h9999F1111;
			5: return 36'hF888F111F;
			6: return 36'hF888F999F;
			7: return 36'hF11111111;
			8: return 36'hF999F999F;
			9: return 36'hF999F111F;
			default: return '0;
		endcase
	endfunction

	function automatic color_t pixel_shade(input logic [7:0] x, input logic [7:0] y,
		input logic [4:0] h_in, input logic [5:0] m_in);
		int h;
		int m;
		int col;
		int row;
		int px;
		int py;
		int gr;
		int off;
		int d;
		int hour_tens;
		logic [35:0] font;
		logic lit;
		color_t gray;
		h = (h_in > MAX_HOUR) ? MAX_HOUR : int'(h_in);
		m = (m_in > MAX_MINUTE) ? MAX_MINUTE : int'(m_in);
		if (!show_24h) begin
			h = h % 12;
			if (h == 0)
				h = 12;
		end
		hour_tens = h / 10;
		if (!show_24h && h < 10)
			hour_tens = int'(BLANK_DIGIT);
		col = x / CELL_PIXELS;
		row = y / CELL_PIXELS;
		px = x % CELL_PIXELS;
		py = y % CELL_PIXELS;
		gray = color_panel ? COLOR_GRAY : COLOR_WHITE;
		if (col >= COLUMNS || row >= ROWS)
			return color_panel ? COLOR_BLACK : COLOR_WHITE;
		lit = 1'b0;
		if (row >= GLYPH_ROW0 && row < GLYPH_ROW0 + GLYPH_ROWS) begin
			gr = row - GLYPH_ROW0;
			d = -1;
			off = 0;
			if (col >= COLON_COL && col < COLON_COL + COLON_W) begin
				lit = COLON_ROWS[8 - gr];
			end else if (col >= HOUR_TENS_COL && col < HOUR_TENS_COL + GLYPH_W) begin
				d = hour_tens;
				off = col - HOUR_TENS_COL;
			end else if (col >= HOUR_ONES_COL && col < HOUR_ONES_COL + GLYPH_W) begin
				d = h % 10;
				off = col - HOUR_ONES_COL;
			end else if (col >= MIN_TENS_COL && col < MIN_TENS_COL + GLYPH_W) begin
				d = m / 10;
				off = col - MIN_TENS_COL;
			end else if (col >= MIN_ONES_COL && col < MIN_ONES_COL + GLYPH_W) begin
				d = m % 10;
				off = col - MIN_ONES_COL;
			end
			if (d >= 0 && d < 10) begin
				font = digit_font(d);
				lit = font[35 - 4 * gr - off];
			end
		end
		if (lit)
			return (px + py == CELL_PIXELS - 1) ? COLOR_WHITE : gray;
		return (px == py) ? COLOR_BLACK : gray;
	endfunction

	task automatic send_pixel(input logic [7:0] x, input logic [7:0] y,
		input logic [4:0] h, input logic [5:0] m);
		int n;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 16);
			start = 1'b0;
			repeat (n) @(negedge clk);
		end
		start = 1'b1;
		pixel_x = x;
		pixel_y = y;
		hour = h;
		minute = m;
		do @(posedge clk); while (busy !== 1'b0);
		expected_colors.push_back(pixel_shade(x, y, h, m));
	endtask

	task automatic wait_pixels_drained();
		@(negedge clk);
		start = 1'b0;
		while (expected_colors.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_HOUR_FORMAT_24: show_24h = val;
			REG_COLOR_DISPLAY: color_panel = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_grid_edges();
		send_pixel(8'd0, 8'd0, 5'd0, 6'd0);
		send_pixel(8'd143, 8'd167, 5'd23, 6'd59);
		send_pixel(8'd144, 8'd0, 5'd12, 6'd30);
		send_pixel(8'd0, 8'd168, 5'd1, 6'd1);
		send_pixel(8'd255, 8'd255, 5'd31, 6'd63);
		send_pixel(8'd143, 8'd168, 5'd7, 6'd45);
	endtask

	task automatic test_glyphs_and_clamp();
		send_pixel(8'd11, 8'd60, 5'd31, 6'd63);
		send_pixel(8'd71, 8'd72, 5'd24, 6'd60);
		send_pixel(8'd116, 8'd111, 5'd23, 6'd59);
		send_pixel(8'd36, 8'd60, 5'd5, 6'd0);
		// leading zero drawn as a digit
		send_pixel(8'd11, 8'd60, 5'd5, 6'd7);
	endtask

	task automatic test_12h_mode();
		wait_pixels_drained();
		write_reg(REG_HOUR_FORMAT_24, 1'b0);
		send_pixel(8'd11, 8'd60, 5'd0, 6'd0);
		send_pixel(8'd23, 8'd60, 5'd0, 6'd30);
		// blanked leading digit
		send_pixel(8'd11, 8'd60, 5'd5, 6'd0);
		send_pixel(8'd6, 8'd60, 5'd5, 6'd0);
		send_pixel(8'd23, 8'd60, 5'd13, 6'd0);
		send_pixel(8'd23, 8'd60, 5'd31, 6'd0);
		send_pixel(8'd36, 8'd60, 5'd12, 6'd0);
		wait_pixels_drained();
		write_reg(REG_HOUR_FORMAT_24, 1'b1);
	endtask

	task automatic test_mono_panel();
		wait_pixels_drained();
		write_reg(REG_COLOR_DISPLAY, 1'b0);
		send_pixel(8'd200, 8'd10, 5'd10, 6'd10);
		send_pixel(8'd6, 8'd60, 5'd20, 6'd0);
		send_pixel(8'd0, 8'd0, 5'd3, 6'd4);
		send_pixel(8'd1, 8'd0, 5'd3, 6'd4);
		send_pixel(8'd255, 8'd255, 5'd31, 6'd63);
		wait_pixels_drained();
		write_reg(REG_COLOR_DISPLAY, 1'b1);
	endtask

	task automatic test_random_frames();
		logic [7:0] x;
		logic [7:0] y;
		logic [4:0] h;
		logic [5:0] m;
		int pick;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_pixels_drained();
			if (phase < 4) begin
				write_reg(REG_HOUR_FORMAT_24, phase[0]);
				write_reg(REG_COLOR_DISPLAY, phase[1]);
			end else begin
				write_reg(REG_HOUR_FORMAT_24, 1'($urandom_range(0, 1)));
				write_reg(REG_COLOR_DISPLAY, 1'($urandom_range(0, 1)));
			end
			// final phase runs back to back
			gaps_on = (phase < RANDOM_PHASES - 1);
			for (int i = 0; i < PHASE_PIXELS; i++) begin
				pick = $urandom_range(0, 3);
				if (pick < 2) begin
					x = 8'($urandom_range(0, COLUMNS * CELL_PIXELS - 1));
					y = 8'($urandom_range(GLYPH_ROW0 * CELL_PIXELS,
						(GLYPH_ROW0 + GLYPH_ROWS) * CELL_PIXELS - 1));
				end else if (pick == 2) begin
					x = 8'($urandom_range(0, COLUMNS * CELL_PIXELS - 1));
					y = 8'($urandom_range(0, ROWS * CELL_PIXELS - 1));
				end else begin
					x = 8'($urandom_range(0, 255));
					y = 8'($urandom_range(0, 255));
				end
				h = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(24, 31))
					: 5'($urandom_range(0, MAX_HOUR));
				m = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(60, 63))
					: 6'($urandom_range(0, MAX_MINUTE));
				send_pixel(x, y, h, m);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_colors.size() == 0) begin
				$error("pixel_color: no transfer expected, actual %0d", pixel_color);
				fault_count++;
			end else begin
				expected_head = expected_colors.pop_front();
				if (pixel_color !== expected_head) begin
					$error("pixel_color: expected %0d, actual %0d", expected_head, pixel_color);
					fault_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("clock_face_pixel_generator test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		pixel_x = '0;
		pixel_y = '0;
		hour = '0;
		minute = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_HOUR_FORMAT_24;
		cfg_data = 1'b0;
		show_24h = 1'b1;
		color_panel = 1'b1;
		gaps_on = 1'b1;
		fault_count = 0;
		cycle_count = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_grid_edges();
		test_glyphs_and_clamp();
		test_12h_mode();
		test_mono_panel();
		test_random_frames();
		wait_pixels_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("clock_face_pixel_generator test passed");
		else
			$display("clock_face_pixel_generator test failed");
		$finish;
	end

endmodule
